[hw/rtl/timer_deadline_heap_defines.svh]
// assertion helpers for the heap rtl file
`ifndef TIMER_DEADLINE_HEAP_DEFINES_SVH
`define TIMER_DEADLINE_HEAP_DEFINES_SVH

// same-cycle implication
`define TDH_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define TDH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/tdh_pkg.sv]
`default_nettype none
package tdh_pkg;
   // fixed field widths of the channels
   localparam int DL_W  = 48;
   localparam int ID_W  = 16;
   localparam int OCC_W = 11;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_FULL     = 2'd1;
   localparam status_type ST_NO_DL    = 2'd2;
   localparam status_type ST_EMPTY    = 2'd3;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   localparam logic [OCC_W-1:0] MAX_EVENTS_RESET = 11'd1024;
endpackage
`default_nettype wire

[hw/rtl/tdh_if.sv]
`default_nettype none
// request channel
interface tdh_req_if;
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic                      has_deadline;
   logic [tdh_pkg::DL_W-1:0]  deadline_us;
   logic [tdh_pkg::ID_W-1:0]  event_id;
   modport source (output valid, action, has_deadline, deadline_us, event_id, input ready);
   modport sink   (input valid, action, has_deadline, deadline_us, event_id, output ready);
endinterface

// response channel
interface tdh_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [tdh_pkg::ID_W-1:0]  removed_id;
   logic [tdh_pkg::DL_W-1:0]  removed_deadline;
   logic [tdh_pkg::OCC_W-1:0] occupancy;
   logic                      head_valid;
   logic [tdh_pkg::DL_W-1:0]  head_deadline;
   logic [tdh_pkg::ID_W-1:0]  head_id;
   modport source (output valid, status, removed_id, removed_deadline, occupancy,
                   head_valid, head_deadline, head_id, input ready);
   modport sink   (input valid, status, removed_id, removed_deadline, occupancy,
                   head_valid, head_deadline, head_id, output ready);
endinterface

// register write channel
interface tdh_csr_if;
   logic                      valid;
   logic                      ready;
   logic [tdh_pkg::OCC_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/tdh_ram.sv]
`default_nettype none
module tdh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

[hw/rtl/timer_deadline_heap.sv]
// channel | port prefix | direction | content
// request | req         | in        | action, has_deadline, deadline_us, event_id
// response| rsp         | out       | status, removed item, occupancy, head
// register| csr         | in        | max_events write data
// insert: a parent read, then a compare and write, per level climbed; remove:
// one or two child reads, then a write, per level descended; the single read
// port of the heap memory sets both. A new item is taken only in idle, once the
// last one has left the done state; refusals also pass through the done state.
// reset empties the queue at once (count only, no memory pass).
// a finished item waits in the response register while the next one is worked on
`default_nettype none
`include "timer_deadline_heap_defines.svh"
module timer_deadline_heap #(
   parameter int CAPACITY      = 1024,
   parameter int DEADLINE_BITS = 48,
   parameter int ID_BITS       = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   tdh_req_if.sink   req,
   tdh_rsp_if.source rsp,
   tdh_csr_if.sink   csr
);
   import tdh_pkg::*;

   localparam int KEY_W = DEADLINE_BITS + ID_BITS;
   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP      = 3'd1;
   localparam logic [2:0] S_UP_W    = 3'd2;
   localparam logic [2:0] S_DN_LAST = 3'd3;
   localparam logic [2:0] S_DN      = 3'd4;
   localparam logic [2:0] S_DN_C    = 3'd5;
   localparam logic [2:0] S_DN_R    = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [OCC_W-1:0] max_ff;
   logic [KEY_W-1:0] head_ff, head_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] left_ff, left_in;
   logic [KEY_W-1:0] rem_ff, rem_in;
   logic [AW-1:0]    i_ff, i_in;
   status_type       status_ff, status_in;
   logic             rsp_valid_ff;

   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [KEY_W-1:0] mem_wdata, mem_rdata;

   logic [AW:0]      c_full, r_full;
   logic             c_in_range, r_in_range, full;
   logic [KEY_W-1:0] child_val;
   logic [AW-1:0]    child_idx;
   logic [CW-1:0]    count_dec;

   tdh_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // child positions and limit check
   assign c_full     = {i_ff, 1'b1};
   assign r_full     = c_full + (AW+1)'(1);
   assign c_in_range = 32'(c_full) < 32'(count_ff);
   assign r_in_range = 32'(r_full) < 32'(count_ff);
   assign full       = (32'(count_ff) >= 32'(max_ff)) || (32'(count_ff) >= 32'(CAPACITY));
   assign count_dec  = count_ff - CW'(1);

   // smaller child; the right one wins only when strictly smaller
   always_comb begin
      if (state_ff == S_DN_R && mem_rdata < left_ff) begin
         child_val = mem_rdata;
         child_idx = r_full[AW-1:0];
      end else if (state_ff == S_DN_R) begin
         child_val = left_ff;
         child_idx = c_full[AW-1:0];
      end else begin
         child_val = mem_rdata;
         child_idx = c_full[AW-1:0];
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;

   // sequencer: sift up on insert, sift down on remove, refusals straight to S_DONE
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      key_in    = key_ff;
      left_in   = left_ff;
      rem_in    = rem_ff;
      i_in      = i_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_waddr = i_ff;
      mem_wdata = key_ff;
      mem_re    = 1'b0;
      mem_raddr = AW'((i_ff - AW'(1)) >> 1);
      unique case (state_ff) inside
         S_IDLE: begin
            if (req.valid) begin
               status_in = ST_OK;
               rem_in    = '0;
               key_in    = {req.deadline_us[DEADLINE_BITS-1:0], req.event_id[ID_BITS-1:0]};
               i_in      = '0;
               if (req.action == ACT_INSERT) begin
                  if (!req.has_deadline) begin
                     status_in = ST_NO_DL;
                     state_in  = S_DONE;
                  end else if (full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     i_in     = AW'(count_ff);
                     state_in = S_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     rem_in   = head_ff;
                     count_in = count_dec;
                     if (count_dec == '0) begin
                        state_in = S_DONE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(count_dec);
                        state_in  = S_DN_LAST;
                     end
                  end
               end
            end
         end
         S_UP: begin
            if (i_ff == '0) begin
               mem_we   = 1'b1;
               head_in  = key_ff;
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end else begin
               mem_re   = 1'b1;
               state_in = S_UP_W;
            end
         end
         S_UP_W: begin
            mem_we = 1'b1;
            if (mem_rdata <= key_ff) begin
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end else begin
               mem_wdata = mem_rdata;
               i_in      = AW'((i_ff - AW'(1)) >> 1);
               state_in  = S_UP;
            end
         end
         S_DN_LAST: begin
            key_in   = mem_rdata;
            state_in = S_DN;
         end
         S_DN: begin
            if (!c_in_range) begin
               mem_we   = 1'b1;
               if (i_ff == '0) begin
                  head_in = key_ff;
               end
               state_in = S_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = c_full[AW-1:0];
               state_in  = S_DN_C;
            end
         end
         S_DN_C, S_DN_R: begin
            if (state_ff == S_DN_C && r_in_range) begin
               left_in   = mem_rdata;
               mem_re    = 1'b1;
               mem_raddr = r_full[AW-1:0];
               state_in  = S_DN_R;
            end else begin
               mem_we = 1'b1;
               if (key_ff <= child_val) begin
                  if (i_ff == '0) begin
                     head_in = key_ff;
                  end
                  state_in = S_DONE;
               end else begin
                  mem_wdata = child_val;
                  if (i_ff == '0) begin
                     head_in = child_val;
                  end
                  i_in     = child_idx;
                  state_in = S_DN;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         max_ff       <= MAX_EVENTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr.valid) begin
            max_ff <= csr.data;
         end
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      head_ff   <= head_in;
      key_ff    <= key_in;
      left_ff   <= left_in;
      rem_ff    <= rem_in;
      i_ff      <= i_in;
      status_ff <= status_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp.ready)) begin
         rsp.status           <= status_ff;
         rsp.removed_id       <= ID_W'(rem_ff[ID_BITS-1:0]);
         rsp.removed_deadline <= DL_W'(rem_ff[KEY_W-1:ID_BITS]);
         rsp.occupancy        <= OCC_W'(count_ff);
         rsp.head_valid       <= (count_ff != '0);
         rsp.head_id          <= (count_ff != '0) ? ID_W'(head_ff[ID_BITS-1:0]) : '0;
         rsp.head_deadline    <= (count_ff != '0) ? DL_W'(head_ff[KEY_W-1:ID_BITS]) : '0;
      end
   end
   assign rsp.valid = rsp_valid_ff;

   `TDH_ASSERT_NEXT(a_take_busy, clock, reset, req.valid && req.ready, state_ff != S_IDLE)
   `TDH_ASSERT_IMPLY(a_count_cap, clock, reset, 1'b1, 32'(count_ff) <= 32'(CAPACITY))
   `TDH_ASSERT_IMPLY(a_dn_inside, clock, reset, state_ff == S_DN, 32'(i_ff) < 32'(count_ff))
endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import tdh_pkg::*;

   typedef struct packed {
      status_type       status;
      logic [ID_W-1:0]  removed_id;
      logic [DL_W-1:0]  removed_deadline;
      logic [OCC_W-1:0] occupancy;
      logic             head_valid;
      logic [DL_W-1:0]  head_deadline;
      logic [ID_W-1:0]  head_id;
   } timer_result_type;

   typedef enum logic [1:0] {ROW_EVENT, ROW_EVENT_CHECKED, ROW_LIMIT} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic             action;
      logic             has_dl;
      logic [DL_W-1:0]  deadline;
      logic [ID_W-1:0]  id;
      status_type       status;
      logic [OCC_W-1:0] occupancy;
   } timer_row_type;

   localparam int QUEUE_DEPTH = 1024;
   localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};
   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

   logic clock;
   logic reset;

   tdh_req_if req ();
   tdh_rsp_if rsp ();
   tdh_csr_if csr ();

   timer_deadline_heap u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // sorted copy of the pending timer keys, earliest first
   logic [63:0]      pending_keys[$];
   logic [OCC_W-1:0] event_limit;
   timer_result_type due_results[$];
   int               fail_count;
   bit               long_hold;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #60ms;
      $display("TEST FAILED");
      $finish;
   end

   // what the timer queue answers to one accepted item
   function automatic timer_result_type timer_next(logic action, logic has_dl,
                                                   logic [DL_W-1:0] deadline,
                                                   logic [ID_W-1:0] id);
      timer_result_type r;
      int               lim;
      logic [63:0]      key;
      int               pos;
      r   = '0;
      lim = (event_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(event_limit);
      if (action == ACT_INSERT) begin
         if (!has_dl) begin
            r.status = ST_NO_DL;
         end else if (pending_keys.size() >= lim) begin
            r.status = ST_FULL;
         end else begin
            key = {deadline, id};
            pos = 0;
            while (pos < pending_keys.size() && pending_keys[pos] <= key) pos++;
            pending_keys.insert(pos, key);
            r.status = ST_OK;
         end
      end else begin
         if (pending_keys.size() == 0) begin
            r.status = ST_EMPTY;
         end else begin
            key = pending_keys.pop_front();
            r.status           = ST_OK;
            r.removed_id       = key[ID_W-1:0];
            r.removed_deadline = key[ID_W+DL_W-1:ID_W];
         end
      end
      r.occupancy = OCC_W'(pending_keys.size());
      if (pending_keys.size() > 0) begin
         r.head_valid    = 1'b1;
         r.head_deadline = pending_keys[0][ID_W+DL_W-1:ID_W];
         r.head_id       = pending_keys[0][ID_W-1:0];
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // short gaps mostly, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // result side: random stalls, a long hold on request, compare on accept
   initial begin
      int               stall;
      timer_result_type e;
      rsp.ready = 1'b0;
      stall     = 0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: item with no expected result, status %0d", $realtime,
                        rsp.status);
               fail_count++;
            end else begin
               e = due_results.pop_front();
               check_field("status", 64'(e.status), 64'(rsp.status));
               check_field("removed_id", 64'(e.removed_id), 64'(rsp.removed_id));
               check_field("removed_deadline", 64'(e.removed_deadline),
                           64'(rsp.removed_deadline));
               check_field("occupancy", 64'(e.occupancy), 64'(rsp.occupancy));
               check_field("head_valid", 64'(e.head_valid), 64'(rsp.head_valid));
               check_field("head_deadline", 64'(e.head_deadline), 64'(rsp.head_deadline));
               check_field("head_id", 64'(e.head_id), 64'(rsp.head_id));
            end
         end
         if (long_hold) begin
            long_hold = 1'b0;
            stall     = 400;
         end else if (stall == 0) begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            stall--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // offer one item and wait for it to be taken
   task automatic send_event(logic action, logic has_dl, logic [DL_W-1:0] deadline,
                             logic [ID_W-1:0] id);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.action       <= action;
      req.has_deadline <= has_dl;
      req.deadline_us  <= deadline;
      req.event_id     <= id;
      do @(posedge clock); while (!req.ready);
      due_results.insert(due_results.size(), timer_next(action, has_dl, deadline, id));
   endtask

   // change the limit once everything has drained
   task automatic write_limit(logic [OCC_W-1:0] value);
      req.valid <= 1'b0;
      wait (due_results.size() == 0);
      repeat (40) @(posedge clock);
      csr.data  <= value;
      csr.valid <= 1'b1;
      do @(posedge clock); while (!csr.ready);
      event_limit = value;
      csr.valid <= 1'b0;
   endtask

   // random item; narrow deadline range now and then to get ties
   task automatic send_random(int remove_pct);
      logic            action;
      logic            has_dl;
      logic [DL_W-1:0] deadline;
      logic [ID_W-1:0] id;
      action   = ($urandom_range(99) < remove_pct) ? ACT_REMOVE : ACT_INSERT;
      has_dl   = ($urandom_range(99) < 93);
      deadline = DL_W'({$urandom, $urandom});
      id       = ID_W'($urandom);
      if ($urandom_range(3) == 0) deadline = DL_W'($urandom_range(7));
      if ($urandom_range(5) == 0) id = ID_W'($urandom_range(3));
      send_event(action, has_dl, deadline, id);
   endtask

   timer_row_type plan[] = '{
      '{ROW_EVENT_CHECKED, ACT_REMOVE, 1'b1, DL_MAX, ID_MAX, ST_EMPTY, 11'd0},
      '{ROW_EVENT_CHECKED, ACT_INSERT, 1'b0, 48'd9, 16'd1, ST_NO_DL, 11'd0},
      '{ROW_EVENT_CHECKED, ACT_INSERT, 1'b1, DL_MAX, ID_MAX, ST_OK, 11'd1},
      '{ROW_EVENT_CHECKED, ACT_INSERT, 1'b1, 48'd0, 16'd0, ST_OK, 11'd2},
      '{ROW_EVENT, ACT_INSERT, 1'b1, 48'd0, ID_MAX, ST_OK, 11'd0},
      '{ROW_EVENT, ACT_INSERT, 1'b1, 48'd5, 16'd7, ST_OK, 11'd0},
      '{ROW_EVENT, ACT_INSERT, 1'b1, 48'd5, 16'd7, ST_OK, 11'd0},
      '{ROW_EVENT, ACT_INSERT, 1'b1, 48'd5, 16'd3, ST_OK, 11'd0},
      '{ROW_EVENT_CHECKED, ACT_INSERT, 1'b0, DL_MAX, ID_MAX, ST_NO_DL, 11'd6},
      '{ROW_EVENT, ACT_REMOVE, 1'b0, 48'd0, 16'd0, ST_OK, 11'd0},
      '{ROW_EVENT, ACT_REMOVE, 1'b0, 48'd0, 16'd0, ST_OK, 11'd0},
      '{ROW_EVENT, ACT_REMOVE, 1'b0, 48'd0, 16'd0, ST_OK, 11'd0},
      '{ROW_EVENT, ACT_REMOVE, 1'b0, 48'd0, 16'd0, ST_OK, 11'd0},
      '{ROW_EVENT, ACT_REMOVE, 1'b0, 48'd0, 16'd0, ST_OK, 11'd0},
      '{ROW_EVENT_CHECKED, ACT_REMOVE, 1'b0, 48'd0, 16'd0, ST_OK, 11'd0},
      '{ROW_EVENT_CHECKED, ACT_REMOVE, 1'b0, 48'd0, 16'd0, ST_EMPTY, 11'd0},
      // zero limit refuses every insert
      '{ROW_LIMIT, ACT_INSERT, 1'b0, 48'd0, 16'd0, ST_OK, 11'd0},
      '{ROW_EVENT_CHECKED, ACT_INSERT, 1'b1, 48'd1, 16'd1, ST_FULL, 11'd0},
      '{ROW_LIMIT, ACT_INSERT, 1'b0, 48'd0, 16'd2, ST_OK, 11'd2},
      '{ROW_EVENT_CHECKED, ACT_INSERT, 1'b1, 48'd3, 16'd1, ST_OK, 11'd1},
      '{ROW_EVENT_CHECKED, ACT_INSERT, 1'b1, 48'd2, 16'd1, ST_OK, 11'd2},
      '{ROW_EVENT_CHECKED, ACT_INSERT, 1'b1, 48'd1, 16'd1, ST_FULL, 11'd2},
      // limit lowered under the count
      '{ROW_LIMIT, ACT_INSERT, 1'b0, 48'd0, 16'd0, ST_OK, 11'd1},
      '{ROW_EVENT_CHECKED, ACT_INSERT, 1'b1, 48'd1, 16'd1, ST_FULL, 11'd2},
      '{ROW_EVENT_CHECKED, ACT_REMOVE, 1'b0, 48'd0, 16'd0, ST_OK, 11'd1}
   };

   // stimulus
   initial begin
      timer_result_type e;
      fail_count  = 0;
      long_hold   = 1'b0;
      event_limit = MAX_EVENTS_RESET;
      reset       = 1'b1;
      req.valid        = 1'b0;
      req.action       = ACT_INSERT;
      req.has_deadline = 1'b0;
      req.deadline_us  = '0;
      req.event_id     = '0;
      csr.valid = 1'b0;
      csr.data  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_LIMIT) begin
            write_limit(plan[i].id[OCC_W-1:0]);
         end else begin
            send_event(plan[i].action, plan[i].has_dl, plan[i].deadline, plan[i].id);
            if (plan[i].kind == ROW_EVENT_CHECKED) begin
               e = due_results[$];
               check_field("table status", 64'(plan[i].status), 64'(e.status));
               check_field("table occupancy", 64'(plan[i].occupancy), 64'(e.occupancy));
            end
         end
      end

      // limit above capacity, fill to the top with a long result stall
      write_limit(11'h7FF);
      long_hold = 1'b1;
      repeat (1200) send_random(1);
      // drain under a limit far below the count
      write_limit(11'd5);
      repeat (150) send_random(75);
      write_limit(11'd0);
      repeat (40) send_random(30);
      write_limit(11'd1);
      repeat (60) send_random(45);
      write_limit(11'd1024);
      repeat (60) send_random(50);
      req.valid <= 1'b0;

      // drain
      wait (due_results.size() == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/tdh_pkg.sv
hw/rtl/tdh_if.sv
hw/rtl/tdh_ram.sv
hw/rtl/timer_deadline_heap.sv
dv/tb.sv
